@@ rtl/prs_pkg.sv @@
// Package with shared widths, register indexes, reset values and constants of the rail sequencer.
`timescale 1ns / 1ps

package prs_pkg;

    // Field widths
    localparam int ElapsedW   = 11;
    localparam int RpmW       = 32;
    localparam int ModeW      = 2;
    localparam int TimeoutW   = 24;
    localparam int ThresholdW = 8;
    localparam int UptimeW    = 16;
    localparam int ClockW     = 32;
    localparam int TickW      = 7;
    localparam int CfgIndexW  = 2;
    localparam int CfgDataW   = 24;

    // Configuration register indexes
    localparam logic [CfgIndexW-1:0] CFG_SLEEP_TIMEOUT  = 2'd0;
    localparam logic [CfgIndexW-1:0] CFG_PRESS_THRESH   = 2'd1;
    localparam logic [CfgIndexW-1:0] CFG_RESTART_UPTIME = 2'd2;
    localparam logic [CfgIndexW-1:0] CFG_AUTO_AT_RESET  = 2'd3;

    // Configuration reset values
    localparam logic [TimeoutW-1:0]   SleepTimeoutReset  = 24'd120000;
    localparam logic [ThresholdW-1:0] PressThreshReset   = 8'd3;
    localparam logic [UptimeW-1:0]    RestartUptimeReset = 16'd30000;
    localparam logic                  AutoAtResetReset   = 1'b1;

    // Blink dividers and tick counter wrap
    localparam int ActiveBlinkDiv = 10;
    localparam int OffBlinkDiv    = 100;
    localparam logic [TickW-1:0] TickLast = 7'd99;

    // Bit positions inside the rail vector
    localparam int RailAmp    = 0;
    localparam int RailMaster = 1;
    localparam int RailReg    = 2;
    localparam int RailBrain  = 3;
    localparam int RailHead   = 4;
    localparam int RailStat   = 5;
    localparam int RailW      = 6;

endpackage

@@ rtl/prs_if.sv @@
// Valid/ready channel interfaces for the tick words and the result words.
`timescale 1ns / 1ps

interface prs_tick_if;
    logic                                 valid;
    logic                                 ready;
    logic [prs_pkg::ElapsedW-1:0]         elapsed_ms;
    logic                                 button_down;
    logic                                 motor_active;
    logic signed [prs_pkg::RpmW-1:0]      motor_rpm;
    logic                                 leds_hold;
    logic                                 amp_hold;

    modport source (output valid, elapsed_ms, button_down, motor_active, motor_rpm,
                    leds_hold, amp_hold, input ready);
    modport sink (input valid, elapsed_ms, button_down, motor_active, motor_rpm,
                  leds_hold, amp_hold, output ready);
endinterface

interface prs_result_if;
    logic                         valid;
    logic                         ready;
    logic                         amp_on;
    logic                         led_master_on;
    logic                         led_reg_on;
    logic                         brain_on;
    logic                         headlight_on;
    logic                         status_led;
    logic                         restart_req;
    logic                         sleep_req;
    logic [prs_pkg::ModeW-1:0]    power_mode;
    logic                         auto_mode;

    modport source (output valid, amp_on, led_master_on, led_reg_on, brain_on, headlight_on,
                    status_led, restart_req, sleep_req, power_mode, auto_mode, input ready);
    modport sink (input valid, amp_on, led_master_on, led_reg_on, brain_on, headlight_on,
                  status_led, restart_req, sleep_req, power_mode, auto_mode, output ready);
endinterface

@@ rtl/power_rail_sequencer.sv @@
// Top level of the power rail sequencer: input register, step logic and result register.
//
//   Channel  Direction  Contents
//   tick     sink       elapsed_ms, button_down, motor_active, motor_rpm, leds_hold, amp_hold
//   result   source     rail enables, headlight, status LED, restart/sleep, mode, auto flag
//   cfg_*    write      cfg_we, cfg_index, cfg_data (registers 0..3)
//
// One word is taken per cycle while the result side does not stall; a tick word is held in the
// input register, passes the step logic and is then captured in the result register.
// Reset clears the state to the off mode, zero counters and rails, and restores the registers.
// A stalled result holds the result register; the input register still takes one more word if empty.
// A write to auto_at_reset also loads the auto flag at once.
`timescale 1ns / 1ps

module power_rail_sequencer
(
    input  logic                             clk,
    input  logic                             rst_n,
    prs_tick_if.sink                         tick,
    prs_result_if.source                     result,
    input  logic                             cfg_we,
    input  logic [prs_pkg::CfgIndexW-1:0]    cfg_index,
    input  logic [prs_pkg::CfgDataW-1:0]     cfg_data
);

    typedef enum logic [prs_pkg::ModeW-1:0] {
        MODE_ACTIVE = 2'd0,
        MODE_OFF    = 2'd1,
        MODE_SLEEP  = 2'd2
    } mode_t;

    // Configuration registers
    logic [prs_pkg::TimeoutW-1:0]   sleep_timeout_reg;
    logic [prs_pkg::ThresholdW-1:0] press_thresh_reg;
    logic [prs_pkg::UptimeW-1:0]    restart_uptime_reg;
    logic                           auto_at_reset_reg;

    // Input register
    logic                           in_valid_reg;
    logic [prs_pkg::ElapsedW-1:0]   elapsed_reg;
    logic                           button_reg;
    logic                           active_reg;
    logic signed [prs_pkg::RpmW-1:0] rpm_reg;
    logic                           lhold_reg;
    logic                           ahold_reg;

    // Sequencer state
    mode_t                          mode_reg, mode_next;
    logic [prs_pkg::ThresholdW-1:0] press_reg, press_next;
    logic [prs_pkg::ClockW-1:0]     now_reg, now_next;
    logic [prs_pkg::ClockW-1:0]     last_reg, last_next;
    logic [prs_pkg::UptimeW-1:0]    uptime_reg, uptime_next;
    logic [prs_pkg::TickW-1:0]      tick_mod_reg, tick_mod_next;
    logic [prs_pkg::RailW-1:0]      rail_reg, rail_next;
    logic                           auto_reg, auto_next;
    logic                           prev_lhold_reg;
    logic                           prev_ahold_reg;

    // Result register
    logic                           out_valid_reg;
    logic [prs_pkg::RailW-1:0]      out_rail_reg;
    logic                           out_restart_reg, restart_next;
    logic                           out_sleep_reg, sleep_next;
    mode_t                          out_mode_reg;
    logic                           out_auto_reg;

    logic                           advance;
    logic                           take;
    logic [prs_pkg::UptimeW:0]      uptime_sum;
    logic [prs_pkg::ClockW-1:0]     age;
    logic                           fire;
    mode_t                          target;
    logic                           active_hit;
    logic                           off_hit;

    // Handshake: the step fires when the result register is free or being drained
    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign tick.ready = !in_valid_reg || advance;
    assign take       = tick.valid && tick.ready;

    // Step logic for one tick word
    always_comb
    begin
        now_next   = now_reg + prs_pkg::ClockW'(elapsed_reg);
        uptime_sum = {1'b0, uptime_reg} + (prs_pkg::UptimeW + 1)'(elapsed_reg);
        uptime_next = uptime_sum[prs_pkg::UptimeW] ? {prs_pkg::UptimeW{1'b1}}
                                                    : uptime_sum[prs_pkg::UptimeW-1:0];
        tick_mod_next = (tick_mod_reg == prs_pkg::TickLast) ? '0 : tick_mod_reg + 1'b1;

        // Blink points are the multiples of each divider within the tick count range.
        active_hit = 1'b0;
        for (int k = 0; k <= int'(prs_pkg::TickLast); k += prs_pkg::ActiveBlinkDiv)
        begin
            if (tick_mod_next == prs_pkg::TickW'(k))
            begin
                active_hit = 1'b1;
            end
        end
        off_hit = 1'b0;
        for (int k = 0; k <= int'(prs_pkg::TickLast); k += prs_pkg::OffBlinkDiv)
        begin
            if (tick_mod_next == prs_pkg::TickW'(k))
            begin
                off_hit = 1'b1;
            end
        end

        press_next = press_reg;
        last_next  = last_reg;
        if (button_reg)
        begin
            if (press_reg != {prs_pkg::ThresholdW{1'b1}})
            begin
                press_next = press_reg + 1'b1;
            end
            last_next = now_next;
        end
        else if (press_reg != '0)
        begin
            press_next = press_reg - 1'b1;
        end

        fire         = press_next > press_thresh_reg;
        rail_next    = rail_reg;
        auto_next    = auto_reg;
        mode_next    = mode_reg;
        restart_next = 1'b0;
        sleep_next   = 1'b0;
        target       = mode_reg;
        age          = '0;

        if (fire && (uptime_next > restart_uptime_reg))
        begin
            press_next = '0;
            rail_next[prs_pkg::RailBrain] = 1'b0;
            restart_next = 1'b1;
        end
        else
        begin
            if (fire)
            begin
                auto_next = 1'b0;
                rail_next[prs_pkg::RailBrain:prs_pkg::RailAmp] = '1;
            end
            if (auto_next)
            begin
                // Pick the target mode from activity and inactivity age
                age = now_next - last_next;
                if (active_reg)
                begin
                    last_next = now_next;
                    target = MODE_ACTIVE;
                end
                else if (age < prs_pkg::ClockW'(sleep_timeout_reg))
                begin
                    target = MODE_OFF;
                end
                else
                begin
                    target = MODE_SLEEP;
                end

                // Rail changes on a mode change
                if (target != mode_reg)
                begin
                    unique case (target)
                        MODE_ACTIVE:
                        begin
                            rail_next[prs_pkg::RailBrain:prs_pkg::RailAmp] = '1;
                        end
                        MODE_OFF:
                        begin
                            if (!lhold_reg)
                            begin
                                rail_next[prs_pkg::RailMaster] = 1'b0;
                                rail_next[prs_pkg::RailReg] = 1'b0;
                            end
                            rail_next[prs_pkg::RailBrain] = 1'b1;
                            if (!prev_ahold_reg)
                            begin
                                rail_next[prs_pkg::RailAmp] = 1'b0;
                            end
                        end
                        MODE_SLEEP:
                        begin
                            rail_next[prs_pkg::RailBrain:prs_pkg::RailAmp] = '0;
                        end
                        default:
                        begin
                            rail_next = rail_next;
                        end
                    endcase
                    mode_next = target;
                end

                // Hold request edges outside the active mode
                if ((prev_lhold_reg != lhold_reg) && (target != MODE_ACTIVE))
                begin
                    rail_next[prs_pkg::RailMaster] = lhold_reg;
                    rail_next[prs_pkg::RailReg] = lhold_reg;
                end
                if ((prev_ahold_reg != ahold_reg) && ahold_reg && (target != MODE_ACTIVE))
                begin
                    rail_next[prs_pkg::RailAmp] = 1'b1;
                end

                // Headlight follows a strictly positive rpm
                rail_next[prs_pkg::RailHead] = (rpm_reg != '0) && !rpm_reg[prs_pkg::RpmW-1];

                // Status LED blink
                if (((mode_next == MODE_ACTIVE) && active_hit) ||
                    ((mode_next == MODE_OFF) && off_hit))
                begin
                    rail_next[prs_pkg::RailStat] = !rail_next[prs_pkg::RailStat];
                end

                sleep_next = (mode_next == MODE_SLEEP);
            end
        end
    end

    // State, configuration, input and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sleep_timeout_reg  <= prs_pkg::SleepTimeoutReset;
            press_thresh_reg   <= prs_pkg::PressThreshReset;
            restart_uptime_reg <= prs_pkg::RestartUptimeReset;
            auto_at_reset_reg  <= prs_pkg::AutoAtResetReset;
            in_valid_reg       <= 1'b0;
            elapsed_reg        <= '0;
            button_reg         <= 1'b0;
            active_reg         <= 1'b0;
            rpm_reg            <= '0;
            lhold_reg          <= 1'b0;
            ahold_reg          <= 1'b0;
            mode_reg           <= MODE_OFF;
            press_reg          <= '0;
            now_reg            <= '0;
            last_reg           <= '0;
            uptime_reg         <= '0;
            tick_mod_reg       <= '0;
            rail_reg           <= '0;
            auto_reg           <= prs_pkg::AutoAtResetReset;
            prev_lhold_reg     <= 1'b0;
            prev_ahold_reg     <= 1'b0;
            out_valid_reg      <= 1'b0;
            out_rail_reg       <= '0;
            out_restart_reg    <= 1'b0;
            out_sleep_reg      <= 1'b0;
            out_mode_reg       <= MODE_OFF;
            out_auto_reg       <= 1'b0;
        end
        else
        begin
            // Input register
            if (take)
            begin
                in_valid_reg <= 1'b1;
                elapsed_reg  <= tick.elapsed_ms;
                button_reg   <= tick.button_down;
                active_reg   <= tick.motor_active;
                rpm_reg      <= tick.motor_rpm;
                lhold_reg    <= tick.leds_hold;
                ahold_reg    <= tick.amp_hold;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            // State update and result capture
            if (advance)
            begin
                mode_reg        <= mode_next;
                press_reg       <= press_next;
                now_reg         <= now_next;
                last_reg        <= last_next;
                uptime_reg      <= uptime_next;
                tick_mod_reg    <= tick_mod_next;
                rail_reg        <= rail_next;
                auto_reg        <= auto_next;
                if (auto_next && !restart_next)
                begin
                    prev_lhold_reg <= lhold_reg;
                    prev_ahold_reg <= ahold_reg;
                end
                out_valid_reg   <= 1'b1;
                out_rail_reg    <= rail_next;
                out_restart_reg <= restart_next;
                out_sleep_reg   <= sleep_next;
                out_mode_reg    <= mode_next;
                out_auto_reg    <= auto_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // Configuration writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    prs_pkg::CFG_SLEEP_TIMEOUT:
                    begin
                        sleep_timeout_reg <= cfg_data;
                    end
                    prs_pkg::CFG_PRESS_THRESH:
                    begin
                        press_thresh_reg <= cfg_data[prs_pkg::ThresholdW-1:0];
                    end
                    prs_pkg::CFG_RESTART_UPTIME:
                    begin
                        restart_uptime_reg <= cfg_data[prs_pkg::UptimeW-1:0];
                    end
                    prs_pkg::CFG_AUTO_AT_RESET:
                    begin
                        auto_at_reset_reg <= cfg_data[0];
                        auto_reg          <= cfg_data[0];
                    end
                    default:
                    begin
                        auto_at_reset_reg <= auto_at_reset_reg;
                    end
                endcase
            end
        end
    end

    // Result word
    assign result.valid         = out_valid_reg;
    assign result.amp_on        = out_rail_reg[prs_pkg::RailAmp];
    assign result.led_master_on = out_rail_reg[prs_pkg::RailMaster];
    assign result.led_reg_on    = out_rail_reg[prs_pkg::RailReg];
    assign result.brain_on      = out_rail_reg[prs_pkg::RailBrain];
    assign result.headlight_on  = out_rail_reg[prs_pkg::RailHead];
    assign result.status_led    = out_rail_reg[prs_pkg::RailStat];
    assign result.restart_req   = out_restart_reg;
    assign result.sleep_req     = out_sleep_reg;
    assign result.power_mode    = out_mode_reg;
    assign result.auto_mode     = out_auto_reg;

    // A restart tick leaves the press counter empty
    a_restart_clears_press: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && restart_next) |=> (press_reg == '0))
        else $error("press counter not cleared after restart");

    // The tick counter never passes its wrap value
    a_tick_range: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_mod_reg <= prs_pkg::TickLast))
        else $error("tick counter out of range");

    // Manual mode is left only through a configuration write
    a_manual_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (!auto_reg && !cfg_we) |=> !auto_reg)
        else $error("auto mode came back without a write");

    // A sleep request is shown only in auto mode and the sleeping state
    a_sleep_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_sleep_reg) |-> (out_auto_reg && (out_mode_reg == MODE_SLEEP)))
        else $error("sleep request outside the sleeping state");

    // A held tick word is not overwritten while it waits
    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("waiting tick word was dropped");

endmodule
